[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[src/aclr_pkg.sv]
// ----------------------------------------------------------------------------
// aclr_pkg
// Types, constants and keyword tables of the command line recogniser.
// ----------------------------------------------------------------------------
package aclr_pkg;

    // line and id sizing
    localparam int LINE_CAPACITY = 63;
    localparam int MAX_ID_CHARS  = 8;
    localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
    localparam int ID_CNT_W      = $clog2(MAX_ID_CHARS + 2);
    localparam int ID_LEN_W      = 4;
    localparam int ID_CHARS_W    = 64;
    localparam int CMD_CNT_W     = 6;
    localparam int LEN_W         = 6;
    localparam int ACT_W         = 3;

    // decoupling queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID_CHARS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID_LENGTH = 1'd1;

    // special bytes
    localparam logic [7:0] CHR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHR_PRINT_LO  = 8'd32;
    localparam logic [7:0] CHR_PRINT_HI  = 8'd126;
    localparam logic [7:0] CHR_COLON     = 8'h3A;

    // action codes
    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REBOOT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RESET   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TRIP    = 3'd4;

    // command keyword slots (candidate bit positions)
    localparam int NUM_CMDS = 3;
    localparam logic [1:0] CMD_REBOOT = 2'd0;
    localparam logic [1:0] CMD_RESET  = 2'd1;
    localparam logic [1:0] CMD_TRIP   = 2'd2;

    // word moved from the front queue to the back end
    typedef struct packed {
        logic [7:0] data;
        logic       newline;   // newline byte; otherwise a printable byte
    } aclr_item_t;

    typedef struct packed {
        logic [ID_CHARS_W-1:0] id_chars;
        logic [ID_LEN_W-1:0]   id_length;
    } aclr_cfg_t;

    typedef struct packed {
        logic [Q_LVL_W-1:0] level;
        logic               full;
    } aclr_q_stat_t;

    // "CMD:" prefix, character by position
    function automatic logic [7:0] prefix_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h43;  // C
            2'd1:    c = 8'h4D;  // M
            2'd2:    c = 8'h44;  // D
            default: c = CHR_COLON;
        endcase
        return c;
    endfunction

    // length of each command keyword
    function automatic logic [CMD_CNT_W-1:0] cmd_len(input logic [1:0] k);
        logic [CMD_CNT_W-1:0] n;
        unique case (k)
            CMD_REBOOT: n = 6'd6;
            CMD_RESET:  n = 6'd5;
            default:    n = 6'd4;
        endcase
        return n;
    endfunction

    // keyword characters; positions past the keyword read as zero
    function automatic logic [7:0] cmd_char(input logic [1:0] k, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (k)
            CMD_REBOOT: begin
                case (idx)
                    3'd0:    c = 8'h52;  // R
                    3'd1:    c = 8'h45;  // E
                    3'd2:    c = 8'h42;  // B
                    3'd3:    c = 8'h4F;  // O
                    3'd4:    c = 8'h4F;  // O
                    3'd5:    c = 8'h54;  // T
                    default: c = 8'h00;
                endcase
            end
            CMD_RESET: begin
                case (idx)
                    3'd0:    c = 8'h52;  // R
                    3'd1:    c = 8'h45;  // E
                    3'd2:    c = 8'h53;  // S
                    3'd3:    c = 8'h45;  // E
                    3'd4:    c = 8'h54;  // T
                    default: c = 8'h00;
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    c = 8'h54;  // T
                    3'd1:    c = 8'h52;  // R
                    3'd2:    c = 8'h49;  // I
                    3'd3:    c = 8'h50;  // P
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

[src/aclr_front.sv]
// ----------------------------------------------------------------------------
// aclr_front
// Byte intake: drops unprintable bytes other than newline and queues the rest.
// ----------------------------------------------------------------------------
module aclr_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] rx_byte
    output logic                  q_valid,
    input  logic                  q_ready,
    output aclr_pkg::aclr_item_t  q_item,
    output aclr_pkg::aclr_q_stat_t q_stat
);

    aclr_pkg::aclr_item_t                mem_reg [aclr_pkg::Q_DEPTH];
    logic [aclr_pkg::Q_PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [aclr_pkg::Q_PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [aclr_pkg::Q_LVL_W-1:0]        level_reg, level_next;
    logic                                is_print, is_nl, push, pop, full;
    aclr_pkg::aclr_item_t                item_in;

    // classify
    always_comb begin
        is_nl    = (s_tdata == aclr_pkg::CHR_NEWLINE);
        is_print = (s_tdata >= aclr_pkg::CHR_PRINT_LO) && (s_tdata <= aclr_pkg::CHR_PRINT_HI);
        item_in.data    = s_tdata;
        item_in.newline = is_nl;
    end

    assign full     = (level_reg == aclr_pkg::Q_LVL_W'(aclr_pkg::Q_DEPTH));
    assign s_tready = !full;
    assign push     = s_tvalid && s_tready && (is_print || is_nl);
    assign q_valid  = (level_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rd_ptr_reg];

    assign q_stat.level = level_reg;
    assign q_stat.full  = full;

    // pointer and level update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == aclr_pkg::Q_PTR_W'(aclr_pkg::Q_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == aclr_pkg::Q_PTR_W'(aclr_pkg::Q_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

[src/aclr_back.sv]
// ----------------------------------------------------------------------------
// aclr_back
// Incremental line matcher and result register.
// ----------------------------------------------------------------------------
module aclr_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  aclr_pkg::aclr_cfg_t  cfg,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  aclr_pkg::aclr_item_t q_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata     // [2:0] action, [8:3] line_length
);

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_ID     = 2'd1,
        PH_CMD    = 2'd2
    } phase_t;

    logic [aclr_pkg::CNT_W-1:0]     cnt_reg, cnt_next, cnt_line;
    phase_t                         phase_reg, phase_next, phase_line;
    logic                           pfail_reg, pfail_next, pfail_line;
    logic [aclr_pkg::ID_CNT_W-1:0]  idcnt_reg, idcnt_next, idcnt_line;
    logic                           idmis_reg, idmis_next, idmis_line;
    logic [aclr_pkg::CMD_CNT_W-1:0] cmdcnt_reg, cmdcnt_next, cmdcnt_line;
    logic [aclr_pkg::NUM_CMDS-1:0]  cand_reg, cand_next, cand_line;
    logic                           m_valid_reg, m_valid_next;
    logic [15:0]                    m_data_reg, m_data_next;

    logic                           store, line_end, fire;
    logic [7:0]                     b, id_byte;
    logic [aclr_pkg::ID_LEN_W-1:0]  id_len;
    logic [aclr_pkg::ACT_W-1:0]     action;
    logic [aclr_pkg::CMD_CNT_W-1:0] wlen;

    // clamp the configured id length
    assign id_len = (cfg.id_length > aclr_pkg::ID_LEN_W'(aclr_pkg::MAX_ID_CHARS))
                  ? aclr_pkg::ID_LEN_W'(aclr_pkg::MAX_ID_CHARS) : cfg.id_length;
    assign id_byte = cfg.id_chars[8 * 3'(idcnt_reg) +: 8];
    assign b       = q_item.data;

    // absorb one character into the line state
    always_comb begin
        cnt_line    = cnt_reg;
        phase_line  = phase_reg;
        pfail_line  = pfail_reg;
        idcnt_line  = idcnt_reg;
        idmis_line  = idmis_reg;
        cmdcnt_line = cmdcnt_reg;
        cand_line   = cand_reg;
        wlen        = '0;
        store = !q_item.newline && (cnt_reg < aclr_pkg::CNT_W'(aclr_pkg::LINE_CAPACITY));
        if (store) begin
            cnt_line = cnt_reg + 1'b1;
            unique case (phase_reg)
                PH_PREFIX: begin
                    if (b != aclr_pkg::prefix_char(cnt_reg[1:0])) begin
                        pfail_line = 1'b1;
                    end
                    if (cnt_reg == aclr_pkg::CNT_W'(3)) begin
                        phase_line = PH_ID;
                    end
                end
                PH_ID: begin
                    if (b == aclr_pkg::CHR_COLON) begin
                        if (aclr_pkg::ID_LEN_W'(idcnt_reg) != id_len) begin
                            idmis_line = 1'b1;
                        end
                        phase_line = PH_CMD;
                    end else begin
                        if (aclr_pkg::ID_LEN_W'(idcnt_reg) >= id_len || b != id_byte) begin
                            idmis_line = 1'b1;
                        end
                        if (idcnt_reg < aclr_pkg::ID_CNT_W'(aclr_pkg::MAX_ID_CHARS + 1)) begin
                            idcnt_line = idcnt_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    for (int k = 0; k < aclr_pkg::NUM_CMDS; k++) begin
                        wlen = aclr_pkg::cmd_len(2'(k));
                        if (cmdcnt_reg >= wlen ||
                            b != aclr_pkg::cmd_char(2'(k), cmdcnt_reg[2:0])) begin
                            cand_line[k] = 1'b0;
                        end
                    end
                    if (cmdcnt_reg != '1) begin
                        cmdcnt_line = cmdcnt_reg + 1'b1;
                    end
                end
            endcase
        end
        line_end = (q_item.newline || cnt_line >= aclr_pkg::CNT_W'(aclr_pkg::LINE_CAPACITY))
                 && (cnt_line != '0);
    end

    // action of the finished line
    always_comb begin
        action = aclr_pkg::ACT_UNKNOWN;
        if (pfail_line || phase_line != PH_CMD || idmis_line) begin
            action = aclr_pkg::ACT_NONE;
        end else if (cand_line[aclr_pkg::CMD_REBOOT] &&
                     cmdcnt_line == aclr_pkg::cmd_len(aclr_pkg::CMD_REBOOT)) begin
            action = aclr_pkg::ACT_REBOOT;
        end else if (cand_line[aclr_pkg::CMD_RESET] &&
                     cmdcnt_line == aclr_pkg::cmd_len(aclr_pkg::CMD_RESET)) begin
            action = aclr_pkg::ACT_RESET;
        end else if (cand_line[aclr_pkg::CMD_TRIP] &&
                     cmdcnt_line == aclr_pkg::cmd_len(aclr_pkg::CMD_TRIP)) begin
            action = aclr_pkg::ACT_TRIP;
        end
    end

    // a line end waits only when the result register is still occupied
    assign q_ready = !line_end || !m_valid_reg || m_tready;
    assign fire    = q_valid && q_ready;

    // next state
    always_comb begin
        cnt_next     = cnt_reg;
        phase_next   = phase_reg;
        pfail_next   = pfail_reg;
        idcnt_next   = idcnt_reg;
        idmis_next   = idmis_reg;
        cmdcnt_next  = cmdcnt_reg;
        cand_next    = cand_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (fire) begin
            if (line_end) begin
                cnt_next     = '0;
                phase_next   = PH_PREFIX;
                pfail_next   = 1'b0;
                idcnt_next   = '0;
                idmis_next   = 1'b0;
                cmdcnt_next  = '0;
                cand_next    = '1;
                m_valid_next = 1'b1;
                m_data_next  = {7'd0, aclr_pkg::LEN_W'(cnt_line), action};
            end else begin
                cnt_next    = cnt_line;
                phase_next  = phase_line;
                pfail_next  = pfail_line;
                idcnt_next  = idcnt_line;
                idmis_next  = idmis_line;
                cmdcnt_next = cmdcnt_line;
                cand_next   = cand_line;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            phase_reg   <= PH_PREFIX;
            pfail_reg   <= 1'b0;
            idcnt_reg   <= '0;
            idmis_reg   <= 1'b0;
            cmdcnt_reg  <= '0;
            cand_reg    <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            phase_reg   <= phase_next;
            pfail_reg   <= pfail_next;
            idcnt_reg   <= idcnt_next;
            idmis_reg   <= idmis_next;
            cmdcnt_reg  <= cmdcnt_next;
            cand_reg    <= cand_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[src/addressed_command_line_recognizer_core.sv]
// ----------------------------------------------------------------------------
// addressed_command_line_recognizer_core
// Recognises "CMD:<id>:<command>" lines in a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received byte per word. Printable bytes build a line of
//   up to 63 characters; newline, or the 63rd character, closes it.
//   m_* carries one word per non-empty line: action code and line length.
//   cfg_* writes the node id characters (index 0) and id length (index 1);
//   write only while no line result is outstanding.
// Timing:
//   One byte per cycle sustained unless a held result stalls the queue. A byte
//   passes the intake queue (2 words) to the matcher; the result register is
//   loaded when the matcher takes a line's closing byte from the queue.
// Stalls:
//   While a result waits the input keeps running; once the queue fills
//   behind a held result, s_tready drops until m_tready takes the result.
// Reset:
//   aresetn (synchronous, low) empties the queue, the result register and
//   the line state, and clears the node id registers to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module addressed_command_line_recognizer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // [2:0] action, [8:3] line_length
    input  logic                                cfg_we,
    input  logic [aclr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aclr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    aclr_pkg::aclr_cfg_t    cfg_reg, cfg_next;
    aclr_pkg::aclr_item_t   q_item;
    aclr_pkg::aclr_q_stat_t q_stat;
    logic                   q_valid, q_ready;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                aclr_pkg::REG_NODE_ID_CHARS:
                    cfg_next.id_chars = cfg_wdata;
                default:
                    cfg_next.id_length = cfg_wdata[aclr_pkg::ID_LEN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    aclr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .q_stat   (q_stat)
    );

    aclr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // checks
    `ASSERT_PROP(a_len_nonzero, aclk, aresetn, m_tvalid |-> (m_tdata[8:3] != 6'd0))
    `ASSERT_PROP(a_action_range, aclk, aresetn, m_tvalid |-> (m_tdata[2:0] <= aclr_pkg::ACT_TRIP))
    `ASSERT_NEVER(a_q_overfill, aclk, aresetn, q_stat.level > aclr_pkg::Q_LVL_W'(aclr_pkg::Q_DEPTH))
    `ASSERT_PROP(a_full_blocks, aclk, aresetn, q_stat.full |-> !s_tready)

endmodule
